// ----- src/sfp_pkg.sv -----
package sfp_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int COMP_W        = 8;
   localparam int NUM_LANES     = 3;
   localparam int PIX_W         = COMP_W * NUM_LANES;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [1:0] {
      LAYOUT_INTERLEAVED  = 2'd0,
      LAYOUT_SIDE_BY_SIDE = 2'd1,
      LAYOUT_OVER_UNDER   = 2'd2,
      LAYOUT_ANAGLYPH     = 2'd3
   } layout_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAYOUT_MODE = 2'd0,
      CSR_HALF_HEIGHT = 2'd1,
      CSR_HALF_WIDTH  = 2'd2,
      CSR_IS_RGB      = 2'd3
   } csr_reg_type;

   // Per-lane averaging controls for one item.
   typedef struct packed {
      logic vavg;   // average with the stored even row
      logic havg;   // average with the pending pixel
      logic hold;   // capture this pixel as the pending pixel
   } lane_ctl_type;

   // Routing information that travels with an item toward the merge stage.
   typedef struct packed {
      logic sel;    // image the pixel belongs to
      logic rend;   // input row end
      logic have;   // averaging produced a pixel
   } item_info_type;

endpackage

// ----- src/sfp_ram.sv -----
module sfp_ram import sfp_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_DEF,
   parameter int WIDTH = PIX_W,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sfp_lane.sv -----
module sfp_lane import sfp_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  lane_ctl_type      ctl,
   input  logic [COMP_W-1:0] pix,
   input  logic [COMP_W-1:0] stored,
   output logic [COMP_W-1:0] result
);

   logic [COMP_W-1:0] pend_ff;
   logic [COMP_W:0]   vsum;
   logic [COMP_W-1:0] vval;
   logic [COMP_W:0]   hsum;

   // Vertical average first, then the horizontal one; both truncate.
   assign vsum   = {1'b0, stored} + {1'b0, pix};
   assign vval   = ctl.vavg ? vsum[COMP_W:1] : pix;
   assign hsum   = {1'b0, pend_ff} + {1'b0, vval};
   assign result = ctl.havg ? hsum[COMP_W:1] : vval;

   always_ff @(posedge clock) begin
      if (advance && ctl.hold) begin
         pend_ff <= vval;
      end
   end

endmodule

// ----- src/sfp_merge.sv -----
module sfp_merge import sfp_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int CW       = $clog2(MAX_WIDTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s1_valid,
   input  item_info_type        info,
   input  logic [CW-1:0]        ocol,
   input  logic [PIX_W-1:0]     lane_pix,
   input  layout_type           layout,
   input  logic                 is_rgb,
   output logic                 take,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   logic              move;
   logic              ana;
   logic              emit;
   logic              red_we;
   logic [COMP_W-1:0] red_rd;
   logic              s2_v_ff;
   logic              s2_v_in;
   logic [PIX_W-1:0]  s2_pix_ff;
   logic              s2_rend_ff;
   logic              s2_sel_ff;

   assign take   = !s2_v_ff || rsp_tready;
   assign move   = s1_valid && take;
   assign ana    = (layout == LAYOUT_ANAGLYPH);
   // In anaglyph, first-image pixels only deposit their red value.
   assign emit   = info.have && !(ana && !info.sel);
   assign red_we = move && info.have && ana && !info.sel;
   assign s2_v_in = take ? (s1_valid && emit) : s2_v_ff;

   sfp_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (COMP_W)
   ) u_red_store (
      .clock   (clock),
      .wr_en   (red_we),
      .wr_addr (ocol),
      .wr_data (lane_pix[COMP_W-1:0]),
      .rd_en   (move),
      .rd_addr (ocol),
      .rd_data (red_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
      if (move) begin
         s2_pix_ff  <= lane_pix;
         s2_rend_ff <= info.rend;
         s2_sel_ff  <= info.sel;
      end
   end

   always_comb begin
      rsp_tdata = s2_pix_ff;
      rsp_tuser = 1'b0;
      rsp_tlast = s2_rend_ff;
      case (layout)
         LAYOUT_SIDE_BY_SIDE: begin
            rsp_tlast = s2_rend_ff && s2_sel_ff;
         end
         LAYOUT_ANAGLYPH: begin
            if (is_rgb) begin
               rsp_tdata[COMP_W-1:0] = red_rd;
            end else begin
               rsp_tdata = '0;
               rsp_tuser = 1'b1;
            end
         end
         default: begin
            rsp_tlast = s2_rend_ff;
         end
      endcase
   end

   assign rsp_tvalid = s2_v_ff;

endmodule

// ----- src/stereo_frame_packer.sv -----
// Stereo frame packer: takes a stream of pixels from the two images of a stereo
// pair and packs them into one frame as interleaved rows, side by side,
// over-under or a red/cyan anaglyph. Rows of the first image are followed by the
// matching rows of the second (for over-under, the whole first image comes
// first). Optional half height averages row pairs through a line store of
// MAX_WIDTH pixels, and optional half width averages adjacent pixel pairs; both
// truncate and an unpaired last row or column produces nothing. Each accepted
// item gives zero or one result item. One item is accepted every clock cycle
// when the output side keeps up; an item's result is registered with the line
// store read in the first stage, then with the anaglyph red store read in the
// merge stage. The three color components run in three identical averaging
// lanes, and a merge stage applies the layout. Configuration is written through
// the csr port only while no items are in flight; users ensure it, not the block.
module stereo_frame_packer import sfp_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   localparam int CW       = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input pixel channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // in_c0 [7:0], in_c1 [15:8], in_c2 [23:16]
   input  logic                  req_tlast,   // row_end
   input  logic                  req_tuser,   // image_sel
   // Packed pixel channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // out_c0 [7:0], out_c1 [15:8], out_c2 [23:16]
   output logic                  rsp_tlast,   // out_row_end
   output logic                  rsp_tuser,   // mode_error
   // Configuration write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

   // Configuration registers.
   layout_type layout_ff;
   logic       half_height_ff;
   logic       half_width_ff;
   logic       is_rgb_ff;

   // Row and column tracking.
   logic [CW-1:0] col_ff;
   logic          row_par_ff;
   logic          pix_par_ff;
   logic          last_sel_ff;

   // First stage, holding an item whose line store read is in flight.
   logic          s1_v_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   lane_ctl_type  s1_ctl_ff;
   item_info_type s1_info_ff;
   logic [CW-1:0] s1_ocol_ff;

   logic          adv1;
   logic          accept;
   logic          take;
   logic          row_start;
   logic          par;
   logic          store_even;
   logic          have_v;
   logic          hold;
   logic          havg;
   logic          pix_par_in;
   logic [PIX_W-1:0] pix_in;
   logic [PIX_W-1:0] even_rd;
   logic [PIX_W-1:0] lane_pix;
   logic [CW-1:0] ocol_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff      <= LAYOUT_SIDE_BY_SIDE;
         half_height_ff <= 1'b0;
         half_width_ff  <= 1'b0;
         is_rgb_ff      <= 1'b1;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_LAYOUT_MODE: layout_ff      <= layout_type'(csr_data[1:0]);
            CSR_HALF_HEIGHT: half_height_ff <= csr_data[0];
            CSR_HALF_WIDTH:  half_width_ff  <= csr_data[0];
            CSR_IS_RGB:      is_rgb_ff      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign adv1       = !s1_v_ff || take;
   assign req_tready = adv1;
   assign accept     = req_tvalid && adv1;

   // Gray pixels carry only component 0.
   assign pix_in = is_rgb_ff ? req_tdata : {{(PIX_W - COMP_W){1'b0}}, req_tdata[COMP_W-1:0]};

   // A row that starts a different image restarts the row pairing.
   assign row_start  = (col_ff == '0);
   assign par        = (row_start && (req_tuser != last_sel_ff)) ? 1'b0 : row_par_ff;
   assign store_even = half_height_ff && !par;
   assign have_v     = !store_even;
   assign hold       = have_v && half_width_ff && !pix_par_ff;
   assign havg       = have_v && half_width_ff && pix_par_ff;
   assign pix_par_in = (have_v && half_width_ff) ? !pix_par_ff : pix_par_ff;
   assign ocol_in    = half_width_ff ? (col_ff >> 1) : col_ff;

   sfp_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (PIX_W)
   ) u_even_row (
      .clock   (clock),
      .wr_en   (accept && store_even),
      .wr_addr (col_ff),
      .wr_data (pix_in),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (even_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_par_ff  <= 1'b0;
         pix_par_ff  <= 1'b0;
         last_sel_ff <= 1'b0;
         s1_v_ff     <= 1'b0;
      end else begin
         if (adv1) begin
            s1_v_ff <= req_tvalid;
         end
         if (accept) begin
            if (row_start) begin
               last_sel_ff <= req_tuser;
            end
            if (req_tlast) begin
               col_ff     <= '0;
               pix_par_ff <= 1'b0;
               row_par_ff <= !par;
            end else begin
               pix_par_ff <= pix_par_in;
               row_par_ff <= par;
               if (col_ff < COL_LAST) begin
                  col_ff <= col_ff + 1'b1;
               end
            end
         end
      end
      if (accept) begin
         s1_pix_ff       <= pix_in;
         s1_ctl_ff.vavg  <= half_height_ff && par;
         s1_ctl_ff.havg  <= havg;
         s1_ctl_ff.hold  <= hold;
         s1_info_ff.sel  <= req_tuser;
         s1_info_ff.rend <= req_tlast;
         s1_info_ff.have <= have_v && !hold;
         s1_ocol_ff      <= ocol_in;
      end
   end

   // One averaging lane per color component.
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      sfp_lane u_lane (
         .clock   (clock),
         .advance (s1_v_ff && take),
         .ctl     (s1_ctl_ff),
         .pix     (s1_pix_ff[g*COMP_W +: COMP_W]),
         .stored  (even_rd[g*COMP_W +: COMP_W]),
         .result  (lane_pix[g*COMP_W +: COMP_W])
      );
   end

   sfp_merge #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_v_ff),
      .info       (s1_info_ff),
      .ocol       (s1_ocol_ff),
      .lane_pix   (lane_pix),
      .layout     (layout_ff),
      .is_rgb     (is_rgb_ff),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // An accepted item always occupies the first stage in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_v_ff)
      else $error("accepted item did not enter the first stage");

   // A row end always returns the column counter to zero.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (col_ff == '0))
      else $error("column counter not cleared at row end");

   // A mode error result carries all-zero components.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("mode error result with nonzero pixel");

   // Only anaglyph with gray pixels may flag a mode error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> ((layout_ff == LAYOUT_ANAGLYPH) && !is_rgb_ff))
      else $error("mode error outside anaglyph gray");

endmodule
